// ===== rtl/pip_pkg.sv =====
// Package for the prefixed integer parser: types, character and radix codes,
// and the digit, prefix and radix-scaling functions shared by the datapath.
// Depends on nothing.
package pip_pkg;

   typedef logic [63:0] value_type;
   typedef logic [7:0]  char_type;
   typedef logic [4:0]  radix_type;

   typedef enum logic [1:0] {
      POS_START,
      POS_SIGN,
      POS_FIRST,
      POS_REST
   } position_type;

   localparam char_type CHAR_MINUS   = 8'h2D;
   localparam char_type CHAR_ZERO    = 8'h30;
   localparam char_type CHAR_LOWER_A = 8'h61;
   localparam char_type CHAR_LOWER_Z = 8'h7A;
   localparam char_type CASE_OFFSET  = 8'h20;
   localparam char_type CHAR_X       = 8'h58;
   localparam char_type CHAR_O       = 8'h4F;
   localparam char_type CHAR_Q       = 8'h51;
   localparam char_type CHAR_T       = 8'h54;
   localparam char_type CHAR_B       = 8'h42;

   localparam radix_type RADIX_NONE = 5'd0;
   localparam radix_type RADIX_BIN  = 5'd2;
   localparam radix_type RADIX_TERN = 5'd3;
   localparam radix_type RADIX_QUAT = 5'd4;
   localparam radix_type RADIX_OCT  = 5'd8;
   localparam radix_type RADIX_DEC  = 5'd10;
   localparam radix_type RADIX_HEX  = 5'd16;

   typedef struct packed {
      value_type value;
      logic      negative;
      logic      wide;
   } finish_type;

   function automatic value_type digit_of(char_type c);
      logic signed [7:0] t;
      logic signed [7:0] v;
      t = signed'(c - CHAR_ZERO);
      v = t;
      if (t > 8'sd16) begin
         if (t < 8'sd23) begin
            v = t - 8'sd7;
         end else begin
            v = t - 8'sd39;
         end
      end
      return {{56{v[7]}}, v};
   endfunction

   function automatic radix_type prefix_radix(char_type c);
      char_type  u;
      radix_type r;
      u = (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ? c - CASE_OFFSET : c;
      case (u)
         CHAR_X:  r = RADIX_HEX;
         CHAR_O:  r = RADIX_OCT;
         CHAR_Q:  r = RADIX_QUAT;
         CHAR_T:  r = RADIX_TERN;
         CHAR_B:  r = RADIX_BIN;
         default: r = RADIX_NONE;
      endcase
      return r;
   endfunction

   // The radix register only ever holds one of the six supported bases.
   function automatic value_type scale(value_type a, radix_type r);
      value_type p;
      case (r)
         RADIX_BIN:  p = a << 1;
         RADIX_TERN: p = (a << 1) + a;
         RADIX_QUAT: p = a << 2;
         RADIX_OCT:  p = a << 3;
         RADIX_HEX:  p = a << 4;
         default:    p = (a << 3) + (a << 1);
      endcase
      return p;
   endfunction

endpackage

// ===== rtl/pip_accum.sv =====
// Parser state machine and accumulator: consumes one registered character per
// cycle unless a last one meets a full output slot; hands magnitudes to the formatting stage. Uses pip_pkg.
module pip_accum (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  pip_pkg::char_type    in_char,
   input  logic                 in_last,
   input  logic                 wide,
   output logic                 in_ready,
   input  logic                 fin_ready,
   output logic                 fin_valid,
   output pip_pkg::finish_type  fin
);
   import pip_pkg::*;

   position_type pos_ff, pos_in;
   logic         neg_ff, neg_in;
   logic         lz_ff, lz_in;
   radix_type    radix_ff, radix_in;
   value_type    acc_ff, acc_in;
   logic         fin_valid_ff, fin_valid_in;
   finish_type   fin_ff, fin_in;

   logic         out_free;
   logic         take;
   value_type    mac;
   radix_type    pr;

   assign out_free  = !fin_valid_ff || fin_ready;
   assign in_ready  = !in_last || out_free;
   assign take      = in_valid && in_ready;
   assign mac       = scale(acc_ff, radix_ff) + digit_of(in_char);
   assign pr        = prefix_radix(in_char);
   assign fin_valid = fin_valid_ff;
   assign fin       = fin_ff;

   always_comb begin
      pos_in       = pos_ff;
      neg_in       = neg_ff;
      lz_in        = lz_ff;
      radix_in     = radix_ff;
      acc_in       = acc_ff;
      fin_in       = fin_ff;
      fin_valid_in = fin_valid_ff && !fin_ready;
      if (take) begin
         unique case (pos_ff)
            POS_START: begin
               if (in_char == CHAR_MINUS) begin
                  neg_in = 1'b1;
                  pos_in = POS_SIGN;
               end else begin
                  lz_in  = (in_char == CHAR_ZERO);
                  acc_in = mac;
                  pos_in = POS_FIRST;
               end
            end
            POS_SIGN: begin
               lz_in  = (in_char == CHAR_ZERO);
               acc_in = mac;
               pos_in = POS_FIRST;
            end
            POS_FIRST: begin
               if (lz_ff && !in_last && pr != RADIX_NONE) begin
                  radix_in = pr;
               end else begin
                  acc_in = mac;
               end
               pos_in = POS_REST;
            end
            POS_REST: begin
               acc_in = mac;
               pos_in = POS_REST;
            end
            default: begin
               pos_in = POS_START;
            end
         endcase
         if (in_last) begin
            fin_in.value    = acc_in;
            fin_in.negative = neg_in;
            fin_in.wide     = wide;
            fin_valid_in    = 1'b1;
            pos_in          = POS_START;
            neg_in          = 1'b0;
            lz_in           = 1'b0;
            radix_in        = RADIX_DEC;
            acc_in          = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_START;
         neg_ff       <= 1'b0;
         lz_ff        <= 1'b0;
         radix_ff     <= RADIX_DEC;
         acc_ff       <= '0;
         fin_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         neg_ff       <= neg_in;
         lz_ff        <= lz_in;
         radix_ff     <= radix_in;
         acc_ff       <= acc_in;
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff <= fin_in;
   end

endmodule

// ===== rtl/pip_format.sv =====
// Result stage: applies the sign, wraps to 32 bits when asked, and holds the
// response register toward the consumer. Uses pip_pkg.
module pip_format (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fin_valid,
   input  pip_pkg::finish_type  fin,
   output logic                 fin_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [63:0]   rsp_value
);
   import pip_pkg::*;

   logic      valid_ff, valid_in;
   value_type value_ff, value_in;
   value_type signed_value;
   logic      load;

   assign fin_ready    = !valid_ff || rsp_ready;
   assign load         = fin_valid && fin_ready;
   assign signed_value = fin.negative ? (~fin.value + 64'd1) : fin.value;
   assign rsp_valid    = valid_ff;
   assign rsp_value    = signed'(value_ff);

   always_comb begin
      valid_in = load ? 1'b1 : (valid_ff && !rsp_ready);
      value_in = value_ff;
      if (load) begin
         if (fin.wide) begin
            value_in = signed_value;
         end else begin
            value_in = {{32{signed_value[31]}}, signed_value[31:0]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== rtl/prefixed_integer_parser_unit.sv =====
// Prefixed integer parser: request and response channels use valid/ready.
// Each request carries one ASCII character and a last-character mark; the
// response carries the signed 64-bit value parsed from the whole string and
// appears only for a request marked last. A leading minus negates the value,
// and a zero followed by X, O, Q, T or B (either case, not last) selects
// base 16, 8, 4, 3 or 2; otherwise base 10 is used.
// The csr port writes the single width register: 0 wraps results to 32 bits
// and sign-extends them, 1 keeps all 64 bits. The user must write it only
// while idle; the block does not enforce this. Throughput is one request per
// cycle while the consumer keeps up. A request passes an input register, the
// accumulate stage and the response register, in that order. The accumulator
// update is one shift-add by the radix plus the digit, the loop that sets the
// cycle time. When the consumer stalls, the response register holds, one more
// finished value waits in the accumulate stage, and requests keep flowing until a
// further last character arrives. Reset clears the parse state, the width
// register and all valid flags; no response is pending after reset.
module prefixed_integer_parser_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic                 csr_write_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pip_pkg::char_type    req_char_code,
   input  logic                 req_last_char,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [63:0]   rsp_parsed_value
);
   import pip_pkg::*;

   logic       wide_ff, wide_in;
   logic       in_valid_ff, in_valid_in;
   char_type   in_char_ff, in_char_in;
   logic       in_last_ff, in_last_in;
   logic       accum_ready;
   logic       fin_valid;
   logic       fin_ready;
   finish_type fin;

   assign req_ready = !in_valid_ff || accum_ready;

   always_comb begin
      wide_in     = csr_write_enable ? csr_write_data : wide_ff;
      in_valid_in = req_valid ? 1'b1 : (in_valid_ff && !accum_ready);
      in_char_in  = in_char_ff;
      in_last_in  = in_last_ff;
      if (req_valid && req_ready) begin
         in_char_in = req_char_code;
         in_last_in = req_last_char;
      end
      if (!req_ready) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff     <= 1'b0;
         in_valid_ff <= 1'b0;
      end else begin
         wide_ff     <= wide_in;
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
      in_last_ff <= in_last_in;
   end

   pip_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_char   (in_char_ff),
      .in_last   (in_last_ff),
      .wide      (wide_ff),
      .in_ready  (accum_ready),
      .fin_ready (fin_ready),
      .fin_valid (fin_valid),
      .fin       (fin)
   );

   pip_format u_format (
      .clock     (clock),
      .reset     (reset),
      .fin_valid (fin_valid),
      .fin       (fin),
      .fin_ready (fin_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_value (rsp_parsed_value)
   );

endmodule

// ===== rtl/pip_checker.sv =====
// Port-level checker for the prefixed integer parser, bound to the top level.
// Depends on prefixed_integer_parser_unit.
module pip_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic signed [63:0]   rsp_parsed_value
);

   // A request is refused only when a response is waiting on a stalled consumer.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled without a stalled response");

   // No response is pending in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_parsed_value))
      else $error("response value changed while stalled");

endmodule

bind prefixed_integer_parser_unit pip_checker u_checker (.*);
